// ===== hdl/bal_pkg.sv =====
// bal_pkg: shared widths, register indexes, reset values and control types
// for the block average low-pass filter. No dependencies.
package bal_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 12;
    localparam int OUT_W      = 12;
    localparam int LEVEL_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEW  = 1'd1;

    // reset weights, Q16 (keep is about 0.9048)
    localparam logic [WEIGHT_W-1:0] KEEP_RESET = 16'd59299;
    localparam logic [WEIGHT_W-1:0] NEW_RESET  = 16'd6236;

    // level marks and limits
    localparam logic [LEVEL_W-1:0] NO_VALUE  = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFE;
    localparam logic [OUT_W-1:0]   OUT_MAX   = 12'd4095;

    // drain sequencer control towards the sum store
    typedef struct packed {
        logic rd_active;  // sum store read address comes from the drain
        logic clr;        // clear the entry being drained
    } t_drain_ctl;

endpackage

// ===== hdl/bal_if.sv =====
// bal_if: valid/ready stream interfaces for the sample input and the result
// output. Depends on bal_pkg.
interface bal_in_if;
    logic                          valid;
    logic                          ready;
    logic [bal_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bal_out_if #(
    parameter int CH_W = 1
);
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic [bal_pkg::OUT_W-1:0]  filtered_value;
    logic                       last;

    modport source (output valid, output channel, output filtered_value, output last,
                    input ready);
    modport sink   (input valid, input channel, input filtered_value, input last,
                    output ready);
endinterface

// ===== hdl/bal_ram.sv =====
// bal_ram: generic single write port, single read port RAM with registered
// read data (read-first on a same-address collision). No dependencies.
module bal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bal_accum.sv =====
// bal_accum: input side. Channel position and scan counters, per-channel sum
// store (read-modify-write with forwarding) and block-end hand-off.
// Depends on bal_pkg, bal_if and bal_ram.
module bal_accum #(
    parameter int CHANNELS    = 2,
    parameter int AVG_SAMPLES = 8,
    parameter int SAMPLE_BITS = 12,
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bal_in_if.sink               i_in,
    output logic                 o_start,
    input  logic                 i_done,
    input  bal_pkg::t_drain_ctl  i_drain,
    input  logic [CH_W-1:0]      i_drain_raddr,
    input  logic [CH_W-1:0]      i_drain_clr_addr,
    output logic [SUM_W-1:0]     o_sum
);

    localparam int BLK_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    localparam int EXT_W = (SAMPLE_BITS > bal_pkg::SAMPLE_W) ? SAMPLE_BITS : bal_pkg::SAMPLE_W;

    logic [CH_W-1:0]        r_pos, n_pos;
    logic [BLK_W-1:0]       r_blk, n_blk;
    logic                   r_busy;
    logic                   r_s1_valid;
    logic [CH_W-1:0]        r_s1_ch;
    logic [SAMPLE_BITS-1:0] r_s1_smp;
    logic                   r_s1_end;
    logic                   r_fw_valid;
    logic [CH_W-1:0]        r_fw_addr;
    logic [SUM_W-1:0]       r_fw_data;
    logic [CHANNELS-1:0]    r_vld;
    logic                   r_rvld;

    logic                   accept;
    logic                   last_pos;
    logic                   last_blk;
    logic [EXT_W-1:0]       smp_ext;
    logic [CH_W-1:0]        raddr;
    logic [SUM_W-1:0]       rdata;
    logic [SUM_W-1:0]       base;
    logic [SUM_W-1:0]       n_sum;
    logic                   we;
    logic [CH_W-1:0]        waddr;
    logic [SUM_W-1:0]       wdata;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_busy;
    assign last_pos   = (r_pos == CH_W'(CHANNELS - 1));
    assign last_blk   = (r_blk == BLK_W'(AVG_SAMPLES - 1));
    // bits above SAMPLE_BITS are dropped
    assign smp_ext    = EXT_W'(i_in.sample);

    // position and scan counters
    always_comb begin
        n_pos = r_pos;
        n_blk = r_blk;
        if (accept) begin
            if (last_pos) begin
                n_pos = '0;
                n_blk = last_blk ? '0 : r_blk + 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_blk      <= '0;
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_blk      <= n_blk;
            r_s1_valid <= accept;
            r_fw_valid <= r_s1_valid;
            // hold off input from block end until the drain has finished
            if (accept && last_pos && last_blk) begin
                r_busy <= 1'b1;
            end else if (i_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // stage 1 payload, and copy of the last sum write for forwarding
    always_ff @(posedge i_clk) begin
        r_s1_ch   <= r_pos;
        r_s1_smp  <= smp_ext[SAMPLE_BITS-1:0];
        r_s1_end  <= last_pos && last_blk;
        r_fw_addr <= r_s1_ch;
        r_fw_data <= n_sum;
    end

    // sum store: entries read as zero until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[raddr];
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
        end
    end

    assign raddr = i_drain.rd_active ? i_drain_raddr : r_pos;

    bal_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CHANNELS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // read-modify-write; forward a write made on the same edge as the read
    always_comb begin
        if (r_fw_valid && (r_fw_addr == r_s1_ch)) begin
            base = r_fw_data;
        end else begin
            base = r_rvld ? rdata : '0;
        end
        n_sum = base + SUM_W'(r_s1_smp);
    end

    assign we    = r_s1_valid || i_drain.clr;
    assign waddr = r_s1_valid ? r_s1_ch : i_drain_clr_addr;
    assign wdata = r_s1_valid ? n_sum : '0;

    assign o_sum   = r_rvld ? rdata : '0;
    assign o_start = r_s1_valid && r_s1_end;

endmodule

// ===== hdl/bal_filter.sv =====
// bal_filter: block-end drain. Walks the channels, forms each mean, runs the
// Q16 single-pole filter against the level store and registers the results.
// Depends on bal_pkg, bal_if and bal_ram.
module bal_filter #(
    parameter int CHANNELS    = 2,
    parameter int AVG_SAMPLES = 8,
    parameter int SAMPLE_BITS = 12,
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_done,
    output bal_pkg::t_drain_ctl             o_drain,
    output logic [CH_W-1:0]                 o_raddr,
    output logic [CH_W-1:0]                 o_clr_addr,
    input  logic [SUM_W-1:0]                i_sum,
    input  logic [bal_pkg::WEIGHT_W-1:0]    i_keep,
    input  logic [bal_pkg::WEIGHT_W-1:0]    i_new,
    bal_out_if.source                       o_out
);

    localparam int LOG2_AVG = $clog2(AVG_SAMPLES);
    localparam int KP_W     = bal_pkg::LEVEL_W + bal_pkg::WEIGHT_W;
    localparam int NP_W     = SAMPLE_BITS + bal_pkg::WEIGHT_W;
    localparam int ACC_W    = KP_W + 1;

    logic                          r_iss_valid;
    logic [CH_W-1:0]               r_iss_ch;
    logic                          r_r_valid;
    logic [CH_W-1:0]               r_r_ch;
    logic                          r_p_valid;
    logic [CH_W-1:0]               r_p_ch;
    logic [KP_W-1:0]               r_p_keep_prod;
    logic [NP_W-1:0]               r_p_new_prod;
    logic                          r_p_nov;
    logic [SAMPLE_BITS-1:0]        r_p_mean;
    logic                          r_out_valid;
    logic [CH_W-1:0]               r_out_ch;
    logic [bal_pkg::OUT_W-1:0]     r_out_value;
    logic                          r_out_last;
    logic [CHANNELS-1:0]           r_lvl_vld;
    logic                          r_lvl_rvld;

    logic                          adv;
    logic                          iss_last;
    logic [CH_W-1:0]               raddr;
    logic [bal_pkg::LEVEL_W-1:0]   lvl_rdata;
    logic [bal_pkg::LEVEL_W-1:0]   lvl;
    logic [SAMPLE_BITS-1:0]        mean;
    logic [ACC_W-1:0]              acc;
    logic [ACC_W-17:0]             acc_hi;
    logic [bal_pkg::LEVEL_W-1:0]   lvl_sat;
    logic [bal_pkg::LEVEL_W-1:0]   n_level;
    logic [bal_pkg::OUT_W-1:0]     n_out_value;
    logic                          lvl_we;

    // whole drain pipeline moves when the output register is free
    assign adv      = !r_out_valid || o_out.ready;
    assign iss_last = (r_iss_ch == CH_W'(CHANNELS - 1));

    // stalled: keep re-reading the entry held in the read stage
    assign raddr = adv ? r_iss_ch : r_r_ch;

    // issue stage, and valid flags of the read, product and output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_valid <= 1'b0;
            r_iss_ch    <= '0;
            r_r_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_iss_valid <= 1'b1;
                r_iss_ch    <= '0;
            end else if (adv && r_iss_valid) begin
                r_iss_valid <= !iss_last;
                r_iss_ch    <= r_iss_ch + 1'b1;
            end
            if (adv) begin
                r_r_valid   <= r_iss_valid;
                r_p_valid   <= r_r_valid;
                r_out_valid <= r_p_valid;
            end
        end
    end

    // level store: entries read as the no-value mark until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld  <= '0;
            r_lvl_rvld <= 1'b0;
        end else begin
            r_lvl_rvld <= r_lvl_vld[raddr];
            if (lvl_we) begin
                r_lvl_vld[r_p_ch] <= 1'b1;
            end
        end
    end

    bal_ram #(
        .WIDTH (bal_pkg::LEVEL_W),
        .DEPTH (CHANNELS)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (r_p_ch),
        .i_wdata (n_level),
        .i_raddr (raddr),
        .o_rdata (lvl_rdata)
    );

    assign lvl  = r_lvl_rvld ? lvl_rdata : bal_pkg::NO_VALUE;
    assign mean = i_sum[SUM_W-1:LOG2_AVG];

    // read stage channel and product stage
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r_ch        <= r_iss_ch;
            r_p_ch        <= r_r_ch;
            r_p_keep_prod <= lvl * i_keep;
            r_p_new_prod  <= mean * i_new;
            r_p_nov       <= (lvl == bal_pkg::NO_VALUE);
            r_p_mean      <= mean;
        end
    end

    // sum, scale and clamp; a channel with no value yet takes the mean as is
    always_comb begin
        acc    = ACC_W'(r_p_keep_prod) + ACC_W'(r_p_new_prod);
        acc_hi = acc[ACC_W-1:16];
        if (acc_hi > (ACC_W-16)'(bal_pkg::LEVEL_MAX)) begin
            lvl_sat = bal_pkg::LEVEL_MAX;
        end else begin
            lvl_sat = acc_hi[bal_pkg::LEVEL_W-1:0];
        end
        n_level = r_p_nov ? bal_pkg::LEVEL_W'(r_p_mean) : lvl_sat;
        if (n_level > bal_pkg::LEVEL_W'(bal_pkg::OUT_MAX)) begin
            n_out_value = bal_pkg::OUT_MAX;
        end else begin
            n_out_value = n_level[bal_pkg::OUT_W-1:0];
        end
    end

    assign lvl_we = adv && r_p_valid;

    // output register
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_out_ch    <= r_p_ch;
            r_out_value <= n_out_value;
            r_out_last  <= (r_p_ch == CH_W'(CHANNELS - 1));
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.channel        = r_out_ch;
    assign o_out.filtered_value = r_out_value;
    assign o_out.last           = r_out_last;

    assign o_drain.rd_active = r_iss_valid || r_r_valid;
    assign o_drain.clr       = adv && r_r_valid;
    assign o_raddr           = raddr;
    assign o_clr_addr        = r_r_ch;
    assign o_done            = lvl_we && (r_p_ch == CH_W'(CHANNELS - 1));

endmodule

// ===== hdl/block_average_lowpass_filter.sv =====
// block_average_lowpass_filter: top level, configuration registers and
// wiring of the input accumulator and the block-end filter drain.
// Depends on bal_pkg, bal_if, bal_accum and bal_filter.
//
// Usage:
//   i_in carries converter samples, channels interleaved in fixed order from
//   channel 0. Each channel sums AVG_SAMPLES samples (a power of two); at the
//   end of a block each mean goes through level = (level*keep + mean*new)>>16
//   and one transaction per channel leaves on o_out, channel order, the
//   final one flagged last. Weights are written on i_cfg_* while idle, a rule
//   for the user that the block does not enforce. Throughput: one sample per
//   cycle inside a block. Ready stays low after the transaction that ends a
//   block while the drain sequencer walks the sum and level memories, one
//   channel a cycle unless the receiver stalls. Results pass the issue, read,
//   product and output stages and leave one per cycle while ready is high.
//   Reset: sums read as zero, levels as the no-value mark (first mean passes
//   unfiltered), weights return to their defaults.
//   A stalled receiver holds the output register and freezes the drain;
//   input stays blocked until the last result of the block is registered.
module block_average_lowpass_filter #(
    parameter int CHANNELS    = 2,
    parameter int AVG_SAMPLES = 8,
    parameter int SAMPLE_BITS = 12,
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bal_in_if.sink                            i_in,
    bal_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [bal_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bal_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [bal_pkg::WEIGHT_W-1:0] r_keep;
    logic [bal_pkg::WEIGHT_W-1:0] r_new;

    bal_pkg::t_drain_ctl          drain;
    logic [CH_W-1:0]              drain_raddr;
    logic [CH_W-1:0]              drain_clr_addr;
    logic [SUM_W-1:0]             sum;
    logic                         start;
    logic                         done;

    // weight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= bal_pkg::KEEP_RESET;
            r_new  <= bal_pkg::NEW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bal_pkg::REG_KEEP: r_keep <= i_cfg_data[bal_pkg::WEIGHT_W-1:0];
                bal_pkg::REG_NEW:  r_new  <= i_cfg_data[bal_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    bal_accum #(
        .CHANNELS    (CHANNELS),
        .AVG_SAMPLES (AVG_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (i_in),
        .o_start          (start),
        .i_done           (done),
        .i_drain          (drain),
        .i_drain_raddr    (drain_raddr),
        .i_drain_clr_addr (drain_clr_addr),
        .o_sum            (sum)
    );

    bal_filter #(
        .CHANNELS    (CHANNELS),
        .AVG_SAMPLES (AVG_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_done     (done),
        .o_drain    (drain),
        .o_raddr    (drain_raddr),
        .o_clr_addr (drain_clr_addr),
        .i_sum      (sum),
        .i_keep     (r_keep),
        .i_new      (r_new),
        .o_out      (o_out)
    );

endmodule

// ===== sim/bal_level_checker.sv =====
// bal_level_checker: watches the sample and result channels and the weight
// port, predicts every filtered level and compares it with what leaves.
// Depends on bal_pkg and bal_if.
`timescale 1ns / 100ps

module bal_level_checker #(
    parameter int CHANNELS    = 2,
    parameter int AVG_SAMPLES = 8,
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int AVG_SHIFT = $clog2(AVG_SAMPLES),
    localparam int SUM_W     = bal_pkg::SAMPLE_W + AVG_SHIFT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bal_in_if                               i_in_bus,
    bal_out_if                              i_out_bus,
    input  logic                            i_cfg_we,
    input  logic [bal_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bal_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic [bal_pkg::OUT_W-1:0] value;
        logic                      last;
    } t_level_result;

    // model copy of the block's registers and state
    logic [bal_pkg::WEIGHT_W-1:0] keep_w;
    logic [bal_pkg::WEIGHT_W-1:0] new_w;
    logic [SUM_W-1:0]             sums   [CHANNELS];
    logic [bal_pkg::LEVEL_W-1:0]  levels [CHANNELS];
    logic [CH_W-1:0]              position;
    logic [AVG_SHIFT:0]           scans;
    t_level_result                levels_due [$];
    int                           fails;

    // one step of the single-pole filter; the no-value mark lets the mean through
    function automatic logic [bal_pkg::LEVEL_W-1:0] next_level(
        input logic [bal_pkg::LEVEL_W-1:0] level,
        input logic [bal_pkg::OUT_W-1:0]   mean);
        logic [32:0] acc;
        if (level == bal_pkg::NO_VALUE) return bal_pkg::LEVEL_W'(mean);
        acc = 33'(level) * 33'(keep_w) + 33'(mean) * 33'(new_w);
        acc = acc >> 16;
        if (acc > 33'(bal_pkg::LEVEL_MAX)) return bal_pkg::LEVEL_MAX;
        return acc[bal_pkg::LEVEL_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        t_level_result             want;
        t_level_result             got;
        logic [bal_pkg::OUT_W-1:0] mean;
        int                        c;
        if (!i_rst_n) begin
            fails    = 0;
            keep_w   = bal_pkg::KEEP_RESET;
            new_w    = bal_pkg::NEW_RESET;
            position = '0;
            scans    = '0;
            for (c = 0; c < CHANNELS; c++) begin
                sums[c]   = '0;
                levels[c] = bal_pkg::NO_VALUE;
            end
            levels_due.delete();
        end else begin
            // weight writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bal_pkg::REG_KEEP: keep_w = i_cfg_data[bal_pkg::WEIGHT_W-1:0];
                    bal_pkg::REG_NEW:  new_w  = i_cfg_data[bal_pkg::WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // result transaction against the oldest expectation
            if (i_out_bus.valid && i_out_bus.ready) begin
                got.channel = i_out_bus.channel;
                got.value   = i_out_bus.filtered_value;
                got.last    = i_out_bus.last;
                if (levels_due.size() == 0) begin
                    $error("unexpected result: channel %0d filtered_value %0d last %0d",
                           got.channel, got.value, got.last);
                    fails++;
                end else begin
                    want = levels_due.pop_front();
                    if (got.channel !== want.channel) begin
                        $error("channel: expected %0d, actual %0d", want.channel, got.channel);
                        fails++;
                    end
                    if (got.value !== want.value) begin
                        $error("filtered_value: expected %0d, actual %0d",
                               want.value, got.value);
                        fails++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, got.last);
                        fails++;
                    end
                end
            end

            // sample transaction: accumulate, and filter at block end
            if (i_in_bus.valid && i_in_bus.ready) begin
                sums[position] = sums[position] + SUM_W'(i_in_bus.sample);
                if (position == CH_W'(CHANNELS - 1)) begin
                    position = '0;
                    if (scans == (AVG_SHIFT + 1)'(AVG_SAMPLES - 1)) begin
                        scans = '0;
                        for (c = 0; c < CHANNELS; c++) begin
                            mean      = bal_pkg::OUT_W'(sums[c] >> AVG_SHIFT);
                            sums[c]   = '0;
                            levels[c] = next_level(levels[c], mean);
                            want.channel = CH_W'(c);
                            want.value   =
                                (levels[c] > bal_pkg::LEVEL_W'(bal_pkg::OUT_MAX)) ?
                                bal_pkg::OUT_MAX : levels[c][bal_pkg::OUT_W-1:0];
                            want.last    = (c == CHANNELS - 1);
                            levels_due.push_back(want);
                        end
                    end else begin
                        scans = scans + 1'b1;
                    end
                end else begin
                    position = position + 1'b1;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= levels_due.size();
    end

endmodule

// ===== sim/tb_block_average_lowpass_filter.sv =====
// tb_block_average_lowpass_filter: clock, reset, sample and weight stimulus
// with random idling on both channels, and the final verdict.
// Depends on bal_pkg, bal_if, block_average_lowpass_filter and bal_level_checker.
`timescale 1ns / 100ps

module tb_block_average_lowpass_filter;

    localparam int CHANNELS    = 2;
    localparam int AVG_SAMPLES = 8;
    localparam int N_PHASES    = 8;
    localparam int DRAIN_HOLD  = 8;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [bal_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [bal_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           gaps_on;
    logic                           stalls_on;
    int                             stall_left;
    int                             fail_count;
    int                             pending;

    bal_in_if              in_bus ();
    bal_out_if #(.CH_W(1)) out_bus ();

    block_average_lowpass_filter #(
        .CHANNELS    (CHANNELS),
        .AVG_SAMPLES (AVG_SAMPLES),
        .SAMPLE_BITS (bal_pkg::SAMPLE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bal_level_checker #(
        .CHANNELS    (CHANNELS),
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_bus     (in_bus),
        .i_out_bus    (out_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // overall time limit
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: bursts of ready low while stalls are enabled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) out_bus.ready <= 1'b1;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            out_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(1, 15);
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // half uniform samples, half at and near the extremes
    function automatic logic [bal_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return bal_pkg::SAMPLE_W'($urandom_range(0, 15));
            3:       return bal_pkg::SAMPLE_W'($urandom_range(4080, 4095));
            default: return bal_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // one sample transaction; valid stays high on return
    task automatic push_sample(input logic [bal_pkg::SAMPLE_W-1:0] value);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid  <= 1'b1;
        in_bus.sample <= value;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    // hold the sender until every due level has left, then let the drain settle
    task automatic pause_until_drained();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_HOLD) @(posedge i_clk);
    endtask

    task automatic write_weights(input logic [bal_pkg::WEIGHT_W-1:0] keep,
                                 input logic [bal_pkg::WEIGHT_W-1:0] upd);
        cfg_we   <= 1'b1;
        cfg_idx  <= bal_pkg::REG_KEEP;
        cfg_data <= bal_pkg::CFG_DATA_W'(keep);
        @(posedge i_clk);
        cfg_idx  <= bal_pkg::REG_NEW;
        cfg_data <= bal_pkg::CFG_DATA_W'(upd);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        logic [bal_pkg::WEIGHT_W-1:0] keep_set [N_PHASES];
        logic [bal_pkg::WEIGHT_W-1:0] new_set  [N_PHASES];
        logic [bal_pkg::SAMPLE_W-1:0] tail [8];
        int                           ph;
        int                           i;
        int                           count;

        in_bus.valid  = 1'b0;
        in_bus.sample = '0;
        cfg_we        = 1'b0;
        cfg_idx       = bal_pkg::REG_KEEP;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        i_rst_n       = 1'b0;

        // phase 0 runs on reset weights; the rest cover extremes, a sum above unity, random pairs and the reset pair
        keep_set[1] = 16'd0;     new_set[1] = 16'd0;
        keep_set[2] = 16'hFFFF;  new_set[2] = 16'hFFFF;   // level grows into saturation
        keep_set[3] = 16'd0;     new_set[3] = 16'hFFFF;
        keep_set[4] = 16'hFFFF;  new_set[4] = 16'd0;
        keep_set[5] = 16'd60000; new_set[5] = 16'd20000;  // sum above unity
        keep_set[6] = bal_pkg::WEIGHT_W'($urandom);
        new_set[6]  = bal_pkg::WEIGHT_W'($urandom);
        keep_set[7] = bal_pkg::KEEP_RESET; new_set[7] = bal_pkg::NEW_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first block passes full-scale and zero means straight through
        for (i = 0; i < 2 * AVG_SAMPLES; i++) push_sample((i % 2 == 0) ? '1 : '0);
        tail = '{12'd2048, 12'd2047, 12'd1, 12'd4094, 12'h555, 12'hAAA, 12'd4095, 12'd0};
        for (i = 0; i < 8; i++) push_sample(tail[i]);

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                pause_until_drained();
                write_weights(keep_set[ph], new_set[ph]);
            end
            // no idling in phase 4 and in the closing phase
            gaps_on   <= (ph != 4) && (ph != N_PHASES - 1);
            stalls_on <= (ph != 4) && (ph != N_PHASES - 1);
            count = $urandom_range(210, 250);
            for (i = 0; i < count; i++) begin
                if ($urandom_range(0, 149) == 0) pause_until_drained();
                push_sample(pick_sample());
            end
        end

        // wait for the last levels, then for anything stray
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
